// ===== rtl/msrr_pkg.sv =====
// msrr_pkg: shared types and constants of the multi-stage range remap block
// no dependencies; used by the top level and msrr_window_eval
`default_nettype none

package msrr_pkg;

	localparam logic [1:0] FUNC_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_XLATE   = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic hit;
		logic zero;
	} eval_flags_t;

endpackage

`default_nettype wire

// ===== rtl/multi_stage_range_remap_min_unit.sv =====
// multi_stage_range_remap_min_unit: top level of the multi-stage range remap block
// depends on msrr_pkg, msrr_win_mem and msrr_window_eval
//
// usage
//   s_* carries commands: tuser selects write window, translate or restart minimum.
//   a write stores one window into the table, a restart sets the running minimum
//   back to 2147483647; neither gives a result.
//   a translate walks the value through every stage and gives one m_* transaction
//   holding the remapped value and the running minimum including it.
//   each stage reads its windows from the table memory, one per cycle, testing
//   each window while the read of the next is in flight; a stage stops at the
//   first window that hits, at an all-zero window or after its last slot.
//   one item is in work at a time; s_tready is high only while the block is idle.
//   after reset all STAGES*ENTRIES table entries (448 by default) are swept to
//   zero, one entry per cycle, with s_tready low.
//   when the receiver stalls the result waits in its register; the block takes
//   the next item meanwhile and holds a new translate result until m_tready.
`default_nettype none

module multi_stage_range_remap_min_unit #(
	parameter int STAGES     = 7,
	parameter int ENTRIES    = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// stage[2:0], slot[8:3], dest_start[40:9], source_start[72:41],
	// span_length[104:73], query_value[136:105], zero fill up to 143
	input  wire logic [143:0] s_tdata,
	// func[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// mapped_value[31:0], least_so_far[63:32]
	output logic      [63:0]  m_tdata
);

	localparam int DEPTH = STAGES * ENTRIES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int STW   = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int VB    = VALUE_BITS;
	localparam int LW    = (VALUE_BITS > 31) ? VALUE_BITS : 31;

	msrr_pkg::state_t state_q, state_d;

	logic [AW-1:0]  addr_q;
	logic [AW-1:0]  base_q;
	logic [SW-1:0]  slot_q;
	logic [STW-1:0] stage_q;
	logic           more_q;
	logic           vld_s1;
	logic           last_s1;
	logic [VB-1:0]  v_q;
	logic [LW-1:0]  least_q;
	logic           m_tvalid_q;
	logic [31:0]    mapped_q;
	logic [31:0]    least_out_q;

	logic [2:0]  in_stage;
	logic [5:0]  in_slot;
	logic [31:0] in_dest;
	logic [31:0] in_src;
	logic [31:0] in_len;
	logic [31:0] in_query;
	logic [1:0]  in_func;

	logic          accept;
	logic          wr_in_range;
	logic [31:0]   wr_addr_full;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [3*VB-1:0] mem_wdata;
	logic          rd_issue;
	logic [3*VB-1:0] rd_data;

	msrr_pkg::eval_flags_t flags;
	logic [VB-1:0] eval_mapped;
	logic          stage_done;
	logic          last_stage;
	logic          out_free;
	logic [LW-1:0] v_wide;
	logic [LW-1:0] new_least;

	always_comb begin
		in_stage = s_tdata[2:0];
		in_slot  = s_tdata[8:3];
		in_dest  = s_tdata[40:9];
		in_src   = s_tdata[72:41];
		in_len   = s_tdata[104:73];
		in_query = s_tdata[136:105];
		in_func  = s_tuser;
	end

	assign s_tready = (state_q == msrr_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign wr_addr_full = 32'(in_stage) * 32'(ENTRIES) + 32'(in_slot);
	assign wr_in_range  = (32'(in_stage) < 32'(STAGES)) && (32'(in_slot) < 32'(ENTRIES));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		if (state_q == msrr_pkg::ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && (in_func == msrr_pkg::FUNC_WRITE) && wr_in_range) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_full[AW-1:0];
			mem_wdata = {VB'(in_dest), VB'(in_src), VB'(in_len)};
		end
	end

	msrr_win_mem #(
		.DEPTH(DEPTH),
		.WIDTH(3 * VB),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (rd_issue),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	msrr_window_eval #(
		.VALUE_BITS(VB)
	) u_eval (
		.value (v_q),
		.window(rd_data),
		.flags (flags),
		.mapped(eval_mapped)
	);

	assign stage_done = vld_s1 && (flags.hit || flags.zero || last_s1);
	assign last_stage = (stage_q == STW'(STAGES - 1));
	assign out_free   = !m_tvalid_q || m_tready;
	assign v_wide     = LW'(v_q);
	assign new_least  = (v_wide < least_q) ? v_wide : least_q;

	always_comb begin
		state_d  = state_q;
		rd_issue = 1'b0;
		unique case (state_q)
			msrr_pkg::ST_CLEAR: begin
				if (addr_q == AW'(DEPTH - 1)) begin
					state_d = msrr_pkg::ST_IDLE;
				end
			end
			msrr_pkg::ST_IDLE: begin
				if (accept && (in_func == msrr_pkg::FUNC_XLATE)) begin
					state_d = msrr_pkg::ST_SCAN;
				end
			end
			msrr_pkg::ST_SCAN: begin
				rd_issue = more_q && !stage_done;
				if (stage_done && last_stage) begin
					state_d = msrr_pkg::ST_DONE;
				end
			end
			msrr_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = msrr_pkg::ST_IDLE;
				end
			end
			default: state_d = msrr_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msrr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// scan counters and read pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			base_q  <= '0;
			slot_q  <= '0;
			stage_q <= '0;
			more_q  <= 1'b0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_issue;
			if (rd_issue) begin
				last_s1 <= (slot_q == SW'(ENTRIES - 1));
			end
			if (state_q == msrr_pkg::ST_CLEAR) begin
				if (addr_q == AW'(DEPTH - 1)) begin
					addr_q <= '0;
				end else begin
					addr_q <= addr_q + AW'(1);
				end
			end else if (state_q == msrr_pkg::ST_IDLE) begin
				addr_q  <= '0;
				base_q  <= '0;
				slot_q  <= '0;
				stage_q <= '0;
				more_q  <= 1'b1;
			end else if (state_q == msrr_pkg::ST_SCAN) begin
				if (stage_done) begin
					if (!last_stage) begin
						addr_q  <= base_q + AW'(ENTRIES);
						base_q  <= base_q + AW'(ENTRIES);
						stage_q <= stage_q + STW'(1);
						slot_q  <= '0;
						more_q  <= 1'b1;
					end
				end else if (rd_issue) begin
					addr_q <= addr_q + AW'(1);
					more_q <= (slot_q != SW'(ENTRIES - 1));
					if (slot_q != SW'(ENTRIES - 1)) begin
						slot_q <= slot_q + SW'(1);
					end
				end
			end
		end
	end

	// working value
	always_ff @(posedge clk) begin
		if (accept && (in_func == msrr_pkg::FUNC_XLATE)) begin
			v_q <= VB'(in_query);
		end else if ((state_q == msrr_pkg::ST_SCAN) && stage_done && flags.hit) begin
			v_q <= eval_mapped;
		end
	end

	// running minimum and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			least_q    <= LW'(msrr_pkg::INT_MAX);
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept && (in_func == msrr_pkg::FUNC_RESTART)) begin
				least_q <= LW'(msrr_pkg::INT_MAX);
			end
			if ((state_q == msrr_pkg::ST_DONE) && out_free) begin
				least_q    <= new_least;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == msrr_pkg::ST_DONE) && out_free) begin
			mapped_q    <= 32'(v_q);
			least_out_q <= 32'(new_least);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {least_out_q, mapped_q};

endmodule

`default_nettype wire

// ===== rtl/msrr_win_mem.sv =====
// msrr_win_mem: window table, one write port and one registered read port
// depends on nothing; instantiated by the top level
`default_nettype none

module msrr_win_mem #(
	parameter int DEPTH = 448,
	parameter int WIDTH = 96,
	parameter int AW    = 9
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/msrr_window_eval.sv =====
// msrr_window_eval: tests a value against one window and forms its remapped value
// depends on msrr_pkg for the flag struct
`default_nettype none

module msrr_window_eval #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic [VALUE_BITS-1:0]   value,
	input  wire logic [3*VALUE_BITS-1:0] window,
	output msrr_pkg::eval_flags_t        flags,
	output logic      [VALUE_BITS-1:0]   mapped
);

	logic [VALUE_BITS-1:0] dest;
	logic [VALUE_BITS-1:0] src;
	logic [VALUE_BITS-1:0] len;
	logic [VALUE_BITS:0]   bound;

	always_comb begin
		dest       = window[3*VALUE_BITS-1:2*VALUE_BITS];
		src        = window[2*VALUE_BITS-1:VALUE_BITS];
		len        = window[VALUE_BITS-1:0];
		// upper bound kept one bit wider so it never wraps
		bound      = {1'b0, src} + {1'b0, len};
		flags.zero = (window == '0);
		flags.hit  = (value >= src) && ({1'b0, value} < bound);
		mapped     = value + dest - src;
	end

endmodule

`default_nettype wire
